FILE: sv/slfu_pkg.sv
// shared types and constants for the sorted lfu glyph cache
// no dependencies
package slfu_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int KEY_W = 16;
	localparam int USE_W = 16;
	localparam int SLOT_W = 6;

	localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [USE_W-1:0] cnt;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE
	} state_t;

endpackage

FILE: sv/slfu_ram.sv
// slot table memory: one write port, one registered read port
// depends on slfu_pkg
module slfu_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [slfu_pkg::IDX_W-1:0]  waddr,
	input  slfu_pkg::entry_t            wdata,
	input  logic                        re,
	input  logic [slfu_pkg::IDX_W-1:0]  raddr,
	output slfu_pkg::entry_t            rdata
);

	slfu_pkg::entry_t mem [slfu_pkg::SLOTS];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/sorted_lfu_glyph_cache_core.sv
// top level: sorted key table with use counts and least-used replacement
// depends on slfu_pkg and slfu_ram
//
// Each request takes the whole block: a scan reads the occupied slots one per
// cycle through the single read port of the slot memory, then an insert
// moves the entries between the old and new place one per cycle, pipelined
// over the same port. The result appears for one cycle with done high and
// must be taken then; the receiver cannot stall it. A new request may be
// issued in the cycle done is high. Occupancy is tracked with a fill count,
// so no clearing pass is needed after reset.
module sorted_lfu_glyph_cache_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [slfu_pkg::KEY_W-1:0]    char_key,
	output logic                          done,
	output logic [slfu_pkg::SLOT_W-1:0]   slot,
	output logic                          found,
	output logic                          evicted,
	output logic [slfu_pkg::KEY_W-1:0]    evicted_key
);

	localparam int IW = slfu_pkg::IDX_W;
	localparam int CW = slfu_pkg::CNT_W;

	slfu_pkg::state_t state_q, state_d;

	logic                       cmd_q;
	logic [slfu_pkg::KEY_W-1:0] key_q;
	logic [CW-1:0]              n_q;
	logic [CW-1:0]              rd_q;
	logic                       vld_s1;
	logic [IW-1:0]              idx_s1;
	logic                       hit_q;
	logic [IW-1:0]              hit_idx_q;
	logic [slfu_pkg::USE_W-1:0] hit_cnt_q;
	logic [CW-1:0]              lt_q;
	logic [IW-1:0]              min_idx_q;
	logic [slfu_pkg::USE_W-1:0] min_cnt_q;
	logic [slfu_pkg::KEY_W-1:0] min_key_q;
	logic [IW-1:0]              tgt_q;
	logic [IW-1:0]              pos_q;
	logic                       up_q;
	logic                       full_q;
	logic                       mv_s1;
	logic [IW-1:0]              mtgt_s1;

	logic             we, re;
	logic [IW-1:0]    waddr, raddr;
	slfu_pkg::entry_t wdata, rdata;

	logic          accept, scan_issue, scan_end, is_full, mv_issue, mv_end;
	logic [CW-1:0] pos_w;
	logic [IW-1:0] pos_c;

	slfu_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy       = (state_q != slfu_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign scan_issue = (state_q == slfu_pkg::ST_SCAN) && (rd_q < n_q);
	assign scan_end   = (state_q == slfu_pkg::ST_SCAN) && (rd_q >= n_q) && !vld_s1;
	assign is_full    = (n_q == CW'(slfu_pkg::SLOTS));
	assign mv_issue   = (state_q == slfu_pkg::ST_MOVE) && (tgt_q != pos_q);
	assign mv_end     = (state_q == slfu_pkg::ST_MOVE) && (tgt_q == pos_q) && !mv_s1;

	// insert position after the victim (if any) is taken out
	always_comb begin
		pos_w = lt_q;
		if (is_full && ({{(CW-IW){1'b0}}, min_idx_q} < lt_q)) begin
			pos_w = lt_q - CW'(1);
		end
		pos_c = pos_w[IW-1:0];
	end

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		re      = 1'b0;
		raddr   = rd_q[IW-1:0];
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = '{key: key_q, cnt: slfu_pkg::USE_W'(1)};
		case (state_q)
			slfu_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = slfu_pkg::ST_SCAN;
				end
			end
			slfu_pkg::ST_SCAN: begin
				re = scan_issue;
				if (scan_end) begin
					if (hit_q) begin
						we    = 1'b1;
						waddr = hit_idx_q;
						wdata = '{key: key_q,
							cnt: (hit_cnt_q == slfu_pkg::USE_MAX) ? hit_cnt_q
								: hit_cnt_q + slfu_pkg::USE_W'(1)};
						state_d = slfu_pkg::ST_IDLE;
					end else if (cmd_q == slfu_pkg::CMD_INSERT && key_q != '0) begin
						state_d = slfu_pkg::ST_MOVE;
					end else begin
						state_d = slfu_pkg::ST_IDLE;
					end
				end
			end
			slfu_pkg::ST_MOVE: begin
				re    = mv_issue;
				raddr = up_q ? tgt_q - IW'(1) : tgt_q + IW'(1);
				if (mv_s1) begin
					we    = 1'b1;
					waddr = mtgt_s1;
					wdata = rdata;
				end else if (mv_end) begin
					we      = 1'b1;
					waddr   = pos_q;
					state_d = slfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slfu_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slfu_pkg::ST_IDLE;
			n_q     <= '0;
			vld_s1  <= 1'b0;
			mv_s1   <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_issue;
			mv_s1   <= mv_issue;
			done    <= (scan_end && (hit_q || !(cmd_q == slfu_pkg::CMD_INSERT
				&& key_q != '0))) || mv_end;
			if (mv_end && !full_q) begin
				n_q <= n_q + CW'(1);
			end
		end
	end

	// request, scan statistics, move pointers and result
	always_ff @(posedge clk) begin
		idx_s1  <= rd_q[IW-1:0];
		mtgt_s1 <= tgt_q;
		if (accept) begin
			cmd_q <= command;
			key_q <= char_key;
			rd_q  <= '0;
			hit_q <= 1'b0;
			lt_q  <= '0;
		end
		if (scan_issue) begin
			rd_q <= rd_q + CW'(1);
		end
		// compare each returned entry against the request key
		if (vld_s1 && state_q == slfu_pkg::ST_SCAN) begin
			if (rdata.key == key_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_cnt_q <= rdata.cnt;
			end
			if (rdata.key < key_q) begin
				lt_q <= lt_q + CW'(1);
			end
			if (idx_s1 == '0 || rdata.cnt < min_cnt_q) begin
				min_idx_q <= idx_s1;
				min_cnt_q <= rdata.cnt;
				min_key_q <= rdata.key;
			end
		end
		// set up the shift between the old and new place
		if (scan_end) begin
			pos_q  <= pos_c;
			full_q <= is_full;
			if (!is_full) begin
				up_q  <= 1'b1;
				tgt_q <= n_q[IW-1:0];
			end else begin
				up_q  <= (min_idx_q >= pos_c);
				tgt_q <= min_idx_q;
			end
			slot        <= hit_q ? slfu_pkg::SLOT_W'(hit_idx_q) : '0;
			found       <= hit_q;
			evicted     <= 1'b0;
			evicted_key <= '0;
		end
		if (mv_issue) begin
			tgt_q <= up_q ? tgt_q - IW'(1) : tgt_q + IW'(1);
		end
		if (mv_end) begin
			slot        <= slfu_pkg::SLOT_W'(pos_q);
			found       <= 1'b1;
			evicted     <= full_q;
			evicted_key <= full_q ? min_key_q : '0;
		end
	end

endmodule

FILE: sv/slfu_checker.sv
// port-level checks for the glyph cache core, attached by bind
// depends on sorted_lfu_glyph_cache_core ports only
module slfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [5:0]  slot,
	input logic        found,
	input logic        evicted,
	input logic [15:0] evicted_key
);

	// an accepted request keeps the block busy in the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// results are single-cycle strobes
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a miss reports nothing
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> slot == '0 && !evicted && evicted_key == '0)
		else $error("miss result not cleared");

	// no victim key without an eviction
	a_evict_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted |-> evicted_key == '0)
		else $error("victim key without eviction");

endmodule

bind sorted_lfu_glyph_cache_core slfu_checker u_slfu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.slot        (slot),
	.found       (found),
	.evicted     (evicted),
	.evicted_key (evicted_key)
);
